// ===== rtl/core/keyed_blake2b_hash_macros.svh =====
// Assertion macros for the keyed BLAKE2b hash core.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef KEYED_BLAKE2B_HASH_MACROS_SVH
`define KEYED_BLAKE2B_HASH_MACROS_SVH
`ifndef SYNTHESIS
`define KBH_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: %m");
`define KBH_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: %m");
`else
`define KBH_ASSERT(label, clk, rst, expr)
`define KBH_ASSERT_IMP(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/kbh_pkg.sv =====
// Shared constants, types and helper functions of the keyed BLAKE2b core.
// No dependencies.
`timescale 1ns / 1ps
package kbh_pkg;

   localparam int WordW       = 64;
   localparam int BlockBytes  = 128;
   localparam int KeyMaxBytes = 64;
   localparam int RoundCount  = 12;
   localparam int BufDepth    = 16;
   localparam int ChainDepth  = 8;

   localparam logic [31:0] ParamBase = 32'h0101_0000;

   typedef logic [WordW-1:0] word_type;

   // request kinds
   localparam logic [1:0] KindStart  = 2'd0;
   localparam logic [1:0] KindKey    = 2'd1;
   localparam logic [1:0] KindMsg    = 2'd2;
   localparam logic [1:0] KindFinish = 2'd3;

   function automatic word_type iv_word(input logic [2:0] idx);
      word_type w;
      case (idx)
         3'd0:    w = 64'h6a09e667f3bcc908;
         3'd1:    w = 64'hbb67ae8584caa73b;
         3'd2:    w = 64'h3c6ef372fe94f82b;
         3'd3:    w = 64'ha54ff53a5f1d36f1;
         3'd4:    w = 64'h510e527fade682d1;
         3'd5:    w = 64'h9b05688c2b3e6c1f;
         3'd6:    w = 64'h1f83d9abfb41bd6b;
         default: w = 64'h5be0cd19137e2179;
      endcase
      return w;
   endfunction

   // message schedule, position 0 in the low nibble of each row
   function automatic logic [3:0] sigma_index(input logic [3:0] round, input logic [3:0] pos);
      logic [3:0]  row;
      logic [63:0] bits;
      row = (round >= 4'd10) ? round - 4'd10 : round;
      case (row)
         4'd0:    bits = 64'hFEDCBA9876543210;
         4'd1:    bits = 64'h357B20C16DF984AE;
         4'd2:    bits = 64'h491763EADF250C8B;
         4'd3:    bits = 64'h8F04A562EBCD1397;
         4'd4:    bits = 64'hD386CB1EFA427509;
         4'd5:    bits = 64'h91EF57D438B0A6C2;
         4'd6:    bits = 64'hB8293670A4DEF15C;
         4'd7:    bits = 64'hA2684F05931CE7BD;
         4'd8:    bits = 64'h5A417D2C803B9EF6;
         default: bits = 64'h0DC3E9BF5167482A;
      endcase
      return bits[{pos, 2'b00} +: 4];
   endfunction

   function automatic word_type rotr(input word_type x, input logic [5:0] n);
      return (x >> n) | (x << (7'd64 - {1'b0, n}));
   endfunction

endpackage

// ===== rtl/core/kbh_if.sv =====
// Handshake channels of the keyed BLAKE2b core: request, digest and key length.
// No dependencies.
`timescale 1ns / 1ps
interface kbh_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [63:0] data_word;
   logic [3:0]  byte_count;
   modport source (output valid, kind, data_word, byte_count, input ready);
   modport sink   (input valid, kind, data_word, byte_count, output ready);
endinterface

interface kbh_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_word;
   logic [2:0]  word_index;
   logic        last;
   modport source (output valid, digest_word, word_index, last, input ready);
   modport sink   (input valid, digest_word, word_index, last, output ready);
endinterface

interface kbh_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] key_length;
   modport source (output valid, key_length, input ready);
   modport sink   (input valid, key_length, output ready);
endinterface

// ===== rtl/core/kbh_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on kbh_pkg for default sizes.
`timescale 1ns / 1ps
module kbh_ram import kbh_pkg::*; #(
   parameter int Width = WordW,
   parameter int Depth = BufDepth
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/core/keyed_blake2b_hash.sv =====
// Keyed BLAKE2b-512 core (RFC 7693): top level with block and chaining RAMs.
// Depends on kbh_pkg, kbh_if, kbh_ram and keyed_blake2b_hash_macros.svh.
`timescale 1ns / 1ps
`include "keyed_blake2b_hash_macros.svh"

// Requests are taken one at a time. A start request writes the eight chaining
// words into their RAM one per cycle. Key and message requests are accepted in
// S_IDLE and packed into the partial word in S_PLACE. A message request that
// finds the 128-byte block full first runs a compression; one that fills the
// block and still has bytes left does the same and then packs the rest. Each
// compression flushes the partial word, loads the eight chaining words, runs 12
// rounds of eight G functions on a 64-bit adder/rotate datapath (message words
// fetched from the block RAM one per half-G), and then reads back, folds and
// writes back the eight chaining words. A finish request runs one compression
// and then hands out the eight digest words on the response channel, which may
// stall it; a further request is accepted while the last word waits to be taken.
// The key length register is sampled at each start request for the parameter
// word; key bytes are bounded by its current value.
module keyed_blake2b_hash import kbh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   kbh_req_if.sink       req_bus,
   kbh_rsp_if.source     rsp_bus,
   kbh_csr_if.sink       csr_bus
);

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_PLACE  = 3'd2;
   localparam logic [2:0] S_CFLUSH = 3'd3;
   localparam logic [2:0] S_CLOAD  = 3'd4;
   localparam logic [2:0] S_CROUND = 3'd5;
   localparam logic [2:0] S_CFIN   = 3'd6;

   localparam int BufAw   = $clog2(BufDepth);
   localparam int ChainAw = $clog2(ChainDepth);

   logic [2:0]  state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [3:0]  round_ff, round_in;
   logic [2:0]  g_ff, g_in;
   logic [1:0]  ph_ff, ph_in;
   word_type    v_ff [16];
   word_type    v_in [16];
   word_type    g_tmp [16];
   logic [7:0]  fill_ff, fill_in;
   word_type    acc_ff, acc_in;
   word_type    ctr_lo_ff, ctr_lo_in;
   word_type    ctr_hi_ff, ctr_hi_in;
   logic [6:0]  key_len_ff, key_len_in;
   logic [6:0]  key_eff_ff, key_eff_in;
   logic        key_open_ff, key_open_in;
   logic [BufDepth-1:0] buf_valid_ff, buf_valid_in;
   logic        buf_rd_valid_ff, buf_rd_valid_in;
   logic        final_ff, final_in;
   logic        key_mode_ff, key_mode_in;
   word_type    data_ff, data_in;
   logic [3:0]  rem_ff, rem_in;
   logic        rsp_valid_ff, rsp_valid_in;
   word_type    rsp_word_ff, rsp_word_in;
   logic [2:0]  rsp_index_ff, rsp_index_in;
   logic        rsp_last_ff, rsp_last_in;

   // RAM ports
   logic               buf_wr_en, buf_rd_en;
   logic [BufAw-1:0]   buf_wr_addr, buf_rd_addr;
   word_type           buf_wr_data, buf_rd_data;
   logic               chain_wr_en, chain_rd_en;
   logic [ChainAw-1:0] chain_wr_addr, chain_rd_addr;
   word_type           chain_wr_data, chain_rd_data;

   // datapath helpers
   logic        accept;
   logic [3:0]  req_n;
   logic [6:0]  key_cur;
   logic [7:0]  room_msg, room_key, room;
   logic [3:0]  take;
   word_type    take_mask;
   logic [127:0] merged;
   logic [3:0]  new_off;
   word_type    gx, sum_a, sum_c, fin_word;
   logic [7:0]  ctr_inc;
   logic [64:0] ctr_sum;
   logic [31:0] param_word;
   logic        fin_advance;

   function automatic logic [1:0] row_amount(input logic [2:0] g, input logic [1:0] r);
      logic [1:0] amt;
      case (g)
         3'd3:    amt = r + 2'd1;   // enter diagonal layout
         3'd7:    amt = 2'd1 - r;   // back to column layout
         default: amt = 2'd1;
      endcase
      return amt;
   endfunction

   kbh_ram #(.Width(WordW), .Depth(BufDepth)) u_block_ram (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (buf_wr_addr),
      .wr_data (buf_wr_data),
      .rd_en   (buf_rd_en),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data)
   );

   kbh_ram #(.Width(WordW), .Depth(ChainDepth)) u_chain_ram (
      .clock   (clock),
      .wr_en   (chain_wr_en),
      .wr_addr (chain_wr_addr),
      .wr_data (chain_wr_data),
      .rd_en   (chain_rd_en),
      .rd_addr (chain_rd_addr),
      .rd_data (chain_rd_data)
   );

   assign req_bus.ready       = (state_ff == S_IDLE);
   assign accept              = req_bus.valid & req_bus.ready;
   assign req_n               = (req_bus.byte_count > 4'd8) ? 4'd8 : req_bus.byte_count;
   assign csr_bus.ready       = 1'b1;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.digest_word = rsp_word_ff;
   assign rsp_bus.word_index  = rsp_index_ff;
   assign rsp_bus.last        = rsp_last_ff;

   assign key_cur    = (key_len_ff > 7'(KeyMaxBytes)) ? 7'(KeyMaxBytes) : key_len_ff;
   assign param_word = ParamBase ^ {17'd0, key_eff_ff, 8'd0} ^ 32'd64;
   assign gx         = buf_rd_valid_ff ? buf_rd_data : '0;
   assign sum_a      = v_ff[0] + v_ff[4] + gx;
   assign sum_c      = v_ff[8] + v_ff[12];
   assign fin_word   = chain_rd_data ^ v_ff[0] ^ v_ff[8];
   assign fin_advance = !(final_ff && rsp_valid_ff && !rsp_bus.ready);

   // byte packing into the partial word
   always_comb begin
      room_msg  = 8'(BlockBytes) - fill_ff;
      room_key  = (fill_ff < {1'b0, key_cur}) ? {1'b0, key_cur} - fill_ff : 8'd0;
      room      = key_mode_ff ? room_key : room_msg;
      take      = (room < {4'd0, rem_ff}) ? room[3:0] : rem_ff;
      take_mask = ~({WordW{1'b1}} << {take, 3'b000});
      merged    = ({64'd0, data_ff & take_mask} << {fill_ff[2:0], 3'b000}) | {64'd0, acc_ff};
      new_off   = {1'b0, fill_ff[2:0]} + take;
   end

   // second half of G with the final rotation, before the row shuffle
   always_comb begin
      g_tmp     = v_ff;
      g_tmp[8]  = sum_c;
      g_tmp[4]  = rotr(v_ff[4] ^ sum_c, 6'd63);
   end

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      round_in        = round_ff;
      g_in            = g_ff;
      ph_in           = ph_ff;
      v_in            = v_ff;
      fill_in         = fill_ff;
      acc_in          = acc_ff;
      key_len_in      = csr_bus.valid ? csr_bus.key_length : key_len_ff;
      key_eff_in      = key_eff_ff;
      key_open_in     = key_open_ff;
      buf_valid_in    = buf_valid_ff;
      buf_rd_valid_in = buf_rd_valid_ff;
      final_in        = final_ff;
      key_mode_in     = key_mode_ff;
      data_in         = data_ff;
      rem_in          = rem_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_bus.ready;
      rsp_word_in     = rsp_word_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_last_in     = rsp_last_ff;
      ctr_inc         = 8'd0;
      buf_wr_en       = 1'b0;
      buf_wr_addr     = fill_ff[6:3];
      buf_wr_data     = acc_ff;
      buf_rd_en       = 1'b0;
      buf_rd_addr     = '0;
      chain_wr_en     = 1'b0;
      chain_wr_addr   = cnt_ff[ChainAw-1:0];
      chain_wr_data   = '0;
      chain_rd_en     = 1'b0;
      chain_rd_addr   = cnt_ff[ChainAw-1:0];

      case (state_ff)
         S_INIT: begin
            chain_wr_en   = 1'b1;
            chain_wr_data = iv_word(cnt_ff[2:0]) ^
                            ((cnt_ff == 4'd0) ? {32'd0, param_word} : '0);
            cnt_in        = cnt_ff + 4'd1;
            if (cnt_ff == 4'(ChainDepth - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_bus.kind)
                  KindStart: begin
                     key_eff_in   = key_cur;
                     key_open_in  = (key_len_ff != 7'd0);
                     fill_in      = 8'd0;
                     acc_in       = '0;
                     buf_valid_in = '0;
                     cnt_in       = 4'd0;
                     state_in     = S_INIT;
                  end
                  KindKey: begin
                     if (key_open_ff && req_n != 4'd0) begin
                        data_in     = req_bus.data_word;
                        rem_in      = req_n;
                        key_mode_in = 1'b1;
                        state_in    = S_PLACE;
                     end
                  end
                  default: begin
                     if (req_bus.kind == KindFinish || req_n != 4'd0) begin
                        // an open key block is padded to a full block
                        if (key_open_ff) begin
                           buf_wr_en   = ~fill_ff[7];
                           buf_valid_in[buf_wr_addr] = buf_valid_ff[buf_wr_addr] | ~fill_ff[7];
                           acc_in      = '0;
                           fill_in     = 8'(BlockBytes);
                           ctr_inc     = 8'(BlockBytes);
                           key_open_in = 1'b0;
                        end
                        data_in     = req_bus.data_word;
                        rem_in      = req_n;
                        key_mode_in = 1'b0;
                        if (req_bus.kind == KindFinish) begin
                           final_in = 1'b1;
                           state_in = S_CFLUSH;
                        end else begin
                           state_in = S_PLACE;
                        end
                     end
                  end
               endcase
            end
         end
         S_PLACE: begin
            if (!key_mode_ff && fill_ff[7]) begin
               final_in = 1'b0;
               state_in = S_CFLUSH;
            end else begin
               if (new_off[3]) begin
                  buf_wr_en   = 1'b1;
                  buf_wr_data = merged[63:0];
                  buf_valid_in[buf_wr_addr] = 1'b1;
                  acc_in      = merged[127:64];
               end else begin
                  acc_in = merged[63:0];
               end
               fill_in = fill_ff + {4'd0, take};
               if (key_mode_ff) begin
                  state_in = S_IDLE;
               end else begin
                  ctr_inc  = {4'd0, take};
                  rem_in   = rem_ff - take;
                  data_in  = data_ff >> {take, 3'b000};
                  state_in = (rem_ff == take) ? S_IDLE : S_PLACE;
               end
            end
         end
         S_CFLUSH: begin
            buf_wr_en = ~fill_ff[7];
            buf_valid_in[buf_wr_addr] = buf_valid_ff[buf_wr_addr] | ~fill_ff[7];
            acc_in    = '0;
            for (int i = 0; i < 8; i++) begin
               v_in[i + 8] = iv_word(3'(i));
            end
            v_in[12]    = iv_word(3'd4) ^ ctr_lo_ff;
            v_in[13]    = iv_word(3'd5) ^ ctr_hi_ff;
            v_in[14]    = final_ff ? ~iv_word(3'd6) : iv_word(3'd6);
            chain_rd_en   = 1'b1;
            chain_rd_addr = '0;
            cnt_in        = 4'd1;
            state_in      = S_CLOAD;
         end
         S_CLOAD: begin
            for (int i = 0; i < 7; i++) begin
               v_in[i] = v_ff[i + 1];
            end
            v_in[7] = chain_rd_data;
            if (cnt_ff < 4'(ChainDepth)) begin
               chain_rd_en = 1'b1;
               cnt_in      = cnt_ff + 4'd1;
            end else begin
               buf_rd_en   = 1'b1;
               buf_rd_addr = sigma_index(4'd0, 4'd0);
               buf_rd_valid_in = buf_valid_ff[buf_rd_addr];
               round_in    = 4'd0;
               g_in        = 3'd0;
               ph_in       = 2'd0;
               state_in    = S_CROUND;
            end
         end
         S_CROUND: begin
            // G always works on positions 0, 4, 8 and 12; rows rotate between calls
            ph_in = ph_ff + 2'd1;
            case (ph_ff)
               2'd0: begin
                  v_in[0]  = sum_a;
                  v_in[12] = rotr(v_ff[12] ^ sum_a, 6'd32);
               end
               2'd1: begin
                  v_in[8]     = sum_c;
                  v_in[4]     = rotr(v_ff[4] ^ sum_c, 6'd24);
                  buf_rd_en   = 1'b1;
                  buf_rd_addr = sigma_index(round_ff, {g_ff, 1'b1});
                  buf_rd_valid_in = buf_valid_ff[buf_rd_addr];
               end
               2'd2: begin
                  v_in[0]  = sum_a;
                  v_in[12] = rotr(v_ff[12] ^ sum_a, 6'd16);
               end
               default: begin
                  for (int r = 0; r < 4; r++) begin
                     for (int j = 0; j < 4; j++) begin
                        v_in[r * 4 + j] =
                           g_tmp[{2'(r), 2'(j) + row_amount(g_ff, 2'(r))}];
                     end
                  end
                  buf_rd_en = 1'b1;
                  if (g_ff == 3'd7) begin
                     buf_rd_addr = sigma_index(round_ff + 4'd1, 4'd0);
                  end else begin
                     buf_rd_addr = sigma_index(round_ff, {g_ff + 3'd1, 1'b0});
                  end
                  buf_rd_valid_in = buf_valid_ff[buf_rd_addr];
                  g_in = g_ff + 3'd1;
                  if (g_ff == 3'd7) begin
                     round_in = round_ff + 4'd1;
                     if (round_ff == 4'(RoundCount - 1)) begin
                        cnt_in   = 4'd0;
                        state_in = S_CFIN;
                     end
                  end
               end
            endcase
         end
         S_CFIN: begin
            if (cnt_ff == 4'd0) begin
               chain_rd_en = 1'b1;
               cnt_in      = 4'd1;
            end else if (fin_advance) begin
               chain_wr_en   = 1'b1;
               chain_wr_addr = 3'(cnt_ff - 4'd1);
               chain_wr_data = fin_word;
               if (final_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = fin_word;
                  rsp_index_in = 3'(cnt_ff - 4'd1);
                  rsp_last_in  = (cnt_ff == 4'(ChainDepth));
               end
               for (int i = 0; i < 7; i++) begin
                  v_in[i]     = v_ff[i + 1];
                  v_in[i + 8] = v_ff[i + 9];
               end
               if (cnt_ff < 4'(ChainDepth)) begin
                  chain_rd_en = 1'b1;
                  cnt_in      = cnt_ff + 4'd1;
               end else begin
                  buf_valid_in = '0;
                  fill_in      = 8'd0;
                  acc_in       = '0;
                  state_in     = final_ff ? S_IDLE : S_PLACE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      ctr_sum   = {1'b0, ctr_lo_ff} + {57'd0, ctr_inc};
      ctr_lo_in = ctr_sum[63:0];
      ctr_hi_in = ctr_hi_ff + {63'd0, ctr_sum[64]};
      if (state_ff == S_IDLE && accept && req_bus.kind == KindStart) begin
         ctr_lo_in = '0;
         ctr_hi_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_INIT;
         cnt_ff          <= 4'd0;
         round_ff        <= 4'd0;
         g_ff            <= 3'd0;
         ph_ff           <= 2'd0;
         fill_ff         <= 8'd0;
         acc_ff          <= '0;
         ctr_lo_ff       <= '0;
         ctr_hi_ff       <= '0;
         key_len_ff      <= 7'd0;
         key_eff_ff      <= 7'd0;
         key_open_ff     <= 1'b0;
         buf_valid_ff    <= '0;
         buf_rd_valid_ff <= 1'b0;
         final_ff        <= 1'b0;
         key_mode_ff     <= 1'b0;
         rem_ff          <= 4'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         round_ff        <= round_in;
         g_ff            <= g_in;
         ph_ff           <= ph_in;
         fill_ff         <= fill_in;
         acc_ff          <= acc_in;
         ctr_lo_ff       <= ctr_lo_in;
         ctr_hi_ff       <= ctr_hi_in;
         key_len_ff      <= key_len_in;
         key_eff_ff      <= key_eff_in;
         key_open_ff     <= key_open_in;
         buf_valid_ff    <= buf_valid_in;
         buf_rd_valid_ff <= buf_rd_valid_in;
         final_ff        <= final_in;
         key_mode_ff     <= key_mode_in;
         rem_ff          <= rem_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff         <= v_in;
      data_ff      <= data_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   `KBH_ASSERT(fill_in_range, clock, reset, fill_ff <= 8'(BlockBytes))
   `KBH_ASSERT_IMP(key_fill_bounded, clock, reset, key_open_ff, fill_ff <= {1'b0, key_eff_ff})
   `KBH_ASSERT_IMP(acc_empty_on_boundary, clock, reset, fill_ff[2:0] == 3'd0, acc_ff == '0)
   `KBH_ASSERT_IMP(rsp_only_from_fin, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_CFIN)

endmodule
